### design/bsf_pkg.sv
// Shared widths, mode codes and the PWM gamma table of the backlight fader.
package bsf_pkg;

    // Field widths of the command and result transactions.
    localparam int MODE_W     = 2;
    localparam int LEVEL_IN_W = 8;
    localparam int MS_W       = 16;
    localparam int DUTY_W     = 8;
    localparam int LEVEL_W    = 7;

    // Brightness is a percentage.
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

    // Command codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FADE = 2'd2;

    // Quadratic gamma: duty = floor(level * level * 255 / 10000).
    typedef logic [DUTY_W-1:0] t_duty_lut [2**LEVEL_W];

    function automatic t_duty_lut build_duty_lut();
        t_duty_lut lut;
        for (int i = 0; i < 2**LEVEL_W; i++) begin
            lut[i] = DUTY_W'((i * i * 255) / 10000);
        end
        return lut;
    endfunction

    localparam t_duty_lut DUTY_LUT = build_duty_lut();

endpackage

### design/bsf_if.sv
// Valid/ready channel interfaces for fader commands and results.
interface bsf_cmd_if
    import bsf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [MODE_W-1:0]     mode;
    logic [LEVEL_IN_W-1:0] level_value;
    logic [MS_W-1:0]       fade_ms;

    modport source (output valid, output mode, output level_value, output fade_ms,
                    input ready);
    modport sink   (input valid, input mode, input level_value, input fade_ms,
                    output ready);
endinterface

interface bsf_res_if
    import bsf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DUTY_W-1:0]  pwm_duty;
    logic [LEVEL_W-1:0] brightness;
    logic               fading;

    modport source (output valid, output pwm_duty, output brightness, output fading,
                    input ready);
    modport sink   (input valid, input pwm_duty, input brightness, input fading,
                    output ready);
endinterface

### design/backlight_smoothstep_fader.sv
// Backlight fader: smoothstep fades over a shared divider/multiplier sequencer.
//
//  Channel  Dir  Handshake                Fields
//  i_cmd    in   i_cmd.valid/i_cmd.ready  mode, level_value, fade_ms
//  o_res    out  o_res.valid/o_res.ready  pwm_duty, brightness, fading
//
// A command that needs no interpolation goes straight to the finish state (accept, then result).
// A tick during a fade runs the sequencer: a restoring divider produces one
// quotient bit per cycle, then one shared multiplier runs three products, the
// first two each followed by an operand setup state, the last by the blend.
// Synchronous active-low reset clears all fade state; there is no clearing pass.
// Commands are taken only while the sequencer is idle; a finished result waits
// in the output register while the next command is accepted.
module backlight_smoothstep_fader
    import bsf_pkg::*;
#(
    parameter int TIME_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bsf_cmd_if.sink      i_cmd,
    bsf_res_if.source    o_res
);

    localparam int MUL_W  = FRAC_BITS + 2;
    localparam int PROD_W = 2 * MUL_W;
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);
    localparam int CMP_W  = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DIV   = 9'b000000010,
        S_MUL1  = 9'b000000100,
        S_PREP2 = 9'b000001000,
        S_MUL2  = 9'b000010000,
        S_PREP3 = 9'b000100000,
        S_MUL3  = 9'b001000000,
        S_BLEND = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    t_state               r_state,   n_state;
    logic [LEVEL_W-1:0]   r_level,   n_level;
    logic [LEVEL_W-1:0]   r_origin,  n_origin;
    logic [LEVEL_W-1:0]   r_goal,    n_goal;
    logic [TIME_BITS-1:0] r_elapsed, n_elapsed;
    logic [TIME_BITS-1:0] r_len,     n_len;
    logic [TIME_BITS-1:0] r_rem,     n_rem;
    logic [FRAC_BITS-1:0] r_quot,    n_quot;
    logic [CNT_W-1:0]     r_cnt,     n_cnt;
    logic [MUL_W-1:0]     r_op_a,    n_op_a;
    logic [MUL_W-1:0]     r_op_b,    n_op_b;
    logic [PROD_W-1:0]    r_prod,    n_prod;
    logic                 r_out_valid, n_out_valid;
    logic [LEVEL_W-1:0]   r_out_level, n_out_level;
    logic                 r_out_fading, n_out_fading;

    logic                 accept;
    logic [LEVEL_W-1:0]   pct;
    logic [TIME_BITS-1:0] ms_sat;
    logic [TIME_BITS-1:0] elapsed_inc;
    logic [TIME_BITS:0]   rem_dbl;
    logic                 rem_ge;
    logic [LEVEL_W-1:0]   delta;
    logic [PROD_W-1:0]    blend;

    assign accept = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);

    // Clamp the requested level and saturate the duration to the timer width.
    assign pct = (i_cmd.level_value > LEVEL_IN_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                               : i_cmd.level_value[LEVEL_W-1:0];
    assign ms_sat = (CMP_W'(i_cmd.fade_ms) > CMP_W'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}}
                                                                         : TIME_BITS'(CMP_W'(i_cmd.fade_ms));
    assign elapsed_inc = r_elapsed + TIME_BITS'(1);

    // One restoring division step: elapsed * 2^F / length, a bit per cycle.
    assign rem_dbl = {r_rem, 1'b0};
    assign rem_ge  = (rem_dbl >= {1'b0, r_len});

    // Magnitude of the fade swing, and the final blend toward the goal.
    assign delta = (r_goal >= r_origin) ? (r_goal - r_origin) : (r_origin - r_goal);
    assign blend = (r_goal >= r_origin)
                 ? (PROD_W'(r_origin) + (r_prod >> FRAC_BITS))
                 : (((PROD_W'(r_origin) << FRAC_BITS) - r_prod) >> FRAC_BITS);

    // Sequencer and datapath next-state logic.
    always_comb begin
        n_state      = r_state;
        n_level      = r_level;
        n_origin     = r_origin;
        n_goal       = r_goal;
        n_elapsed    = r_elapsed;
        n_len        = r_len;
        n_rem        = r_rem;
        n_quot       = r_quot;
        n_cnt        = r_cnt;
        n_op_a       = r_op_a;
        n_op_b       = r_op_b;
        n_prod       = r_prod;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_level  = r_out_level;
        n_out_fading = r_out_fading;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_FIN;
                    if (i_cmd.mode == MODE_TICK) begin
                        if (r_len != '0) begin
                            n_elapsed = elapsed_inc;
                            if (elapsed_inc >= r_len) begin
                                n_len   = '0;
                                n_level = r_goal;
                            end else begin
                                n_rem   = elapsed_inc;
                                n_quot  = '0;
                                n_cnt   = CNT_W'(FRAC_BITS);
                                n_state = S_DIV;
                            end
                        end
                    end else if (i_cmd.mode == MODE_SET ||
                                 (i_cmd.mode == MODE_FADE && i_cmd.fade_ms == '0)) begin
                        n_len   = '0;
                        n_level = pct;
                    end else if (i_cmd.mode == MODE_FADE) begin
                        n_origin  = r_level;
                        n_goal    = pct;
                        n_elapsed = '0;
                        n_len     = ms_sat;
                    end
                end
            end
            S_DIV: begin
                n_rem  = rem_ge ? TIME_BITS'(rem_dbl - {1'b0, r_len}) : TIME_BITS'(rem_dbl);
                n_quot = {r_quot[FRAC_BITS-2:0], rem_ge};
                n_cnt  = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_op_a  = MUL_W'({r_quot[FRAC_BITS-2:0], rem_ge});
                    n_op_b  = MUL_W'({r_quot[FRAC_BITS-2:0], rem_ge});
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                n_prod  = r_op_a * r_op_b;
                n_state = S_PREP2;
            end
            S_PREP2: begin
                // k^2 / 2^F in Q0.F times (3 - 2k) in Q2.F.
                n_op_a  = MUL_W'(r_prod >> FRAC_BITS);
                n_op_b  = (MUL_W'(3) << FRAC_BITS) - (MUL_W'(r_quot) << 1);
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_prod  = r_op_a * r_op_b;
                n_state = S_PREP3;
            end
            S_PREP3: begin
                n_op_a  = MUL_W'(r_prod >> FRAC_BITS);
                n_op_b  = MUL_W'(delta);
                n_state = S_MUL3;
            end
            S_MUL3: begin
                n_prod  = r_op_a * r_op_b;
                n_state = S_BLEND;
            end
            S_BLEND: begin
                n_level = (blend > PROD_W'(LEVEL_MAX)) ? LEVEL_MAX : blend[LEVEL_W-1:0];
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_level  = r_level;
                    n_out_fading = (r_len != '0);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers; control state and fade state clear on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_origin    <= '0;
            r_goal      <= '0;
            r_elapsed   <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_origin    <= n_origin;
            r_goal      <= n_goal;
            r_elapsed   <= n_elapsed;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        r_rem        <= n_rem;
        r_quot       <= n_quot;
        r_cnt        <= n_cnt;
        r_op_a       <= n_op_a;
        r_op_b       <= n_op_b;
        r_prod       <= n_prod;
        r_out_level  <= n_out_level;
        r_out_fading <= n_out_fading;
    end

    // Result transaction.
    assign o_res.valid      = r_out_valid;
    assign o_res.brightness = r_out_level;
    assign o_res.fading     = r_out_fading;
    assign o_res.pwm_duty   = DUTY_LUT[r_out_level];

    // An active fade always has elapsed time short of its length.
    a_elapsed_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != '0) |-> (r_elapsed < r_len))
        else $error("fade elapsed time reached its length while still active");

    // Interpolated brightness never leaves the percent range.
    a_level_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.brightness <= LEVEL_MAX))
        else $error("brightness above full scale");

    // A pending result is never dropped by the sequencer.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> r_out_valid)
        else $error("pending result lost");

    // The tick that completes a fade ends it and lands on the goal.
    a_fade_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.mode == MODE_TICK && r_len != '0 && elapsed_inc >= r_len)
        |=> (r_len == '0 && r_level == r_goal && r_state == S_FIN))
        else $error("final fade tick did not settle on the goal");

endmodule
